// ----- sv/mau_pkg.sv -----
// Shared types and constants of the modular arithmetic unit.
package mau_pkg;

    // Default operand width and modulus after reset.
    localparam int VALUE_WIDTH_DEF = 30;
    localparam int DEFAULT_MODULUS = 998244353;
    localparam int EXP_WIDTH       = 63;
    localparam int OP_WIDTH        = 3;

    // Operation codes.
    localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_NEG = 3'd4;
    localparam logic [OP_WIDTH-1:0] OP_POW = 3'd5;

    // Configuration register indexes.
    localparam logic REG_MODULUS = 1'b0;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_MUL_AB,
        S_POW_TEST,
        S_POW_ACC,
        S_POW_SQ,
        S_DIV_FIN,
        S_EMIT
    } t_state;

    // Operand pair and destination of one modular multiply.
    typedef enum logic [2:0] {
        MS_A_ONE,
        MS_B_ONE,
        MS_A_B,
        MS_ACC_BASE,
        MS_BASE_BASE,
        MS_ACC_A
    } t_mul_sel;

    // Source of the result register.
    typedef enum logic [2:0] {
        RS_NONE,
        RS_ADD,
        RS_SUB,
        RS_NEG,
        RS_ZERO,
        RS_ACC
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     pow_init_a;
        logic     pow_init_b;
        logic     exp_shift;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                mul_done;
        logic                exp_zero;
        logic                exp_lsb;
        logic                mod_small;
        logic                out_free;
        logic [OP_WIDTH-1:0] op;
    } t_status;

endpackage

// ----- sv/mau_modmul.sv -----
// Shared modular multiplier: full product, then bit-serial restoring reduction.
module mau_modmul
    import mau_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_x,
    input  logic [VALUE_WIDTH-1:0] i_y,
    input  logic [VALUE_WIDTH-1:0] i_mod,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_rem
);
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(PW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_prod;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH:0]   w_trial;

    // One product bit shifted into the partial remainder per cycle.
    assign w_trial = {r_rem, r_prod[PW-1]};
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(PW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Product and remainder registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= i_x * i_y;
            r_rem  <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_prod <= {r_prod[PW-2:0], 1'b0};
            if (w_trial >= {1'b0, i_mod}) begin
                r_rem <= VALUE_WIDTH'(w_trial - {1'b0, i_mod});
            end else begin
                r_rem <= w_trial[VALUE_WIDTH-1:0];
            end
        end
    end

endmodule

// ----- sv/mau_datapath.sv -----
// Operand, exponent, accumulator and result registers of the unit.
module mau_datapath
    import mau_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [VALUE_WIDTH-1:0] i_mod,
    input  logic [OP_WIDTH-1:0]    i_op,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    input  logic [EXP_WIDTH-1:0]   i_exp,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [VALUE_WIDTH-1:0] o_result
);
    localparam int W = VALUE_WIDTH;

    logic [OP_WIDTH-1:0]  r_op;
    logic [W-1:0]         r_a, r_b, r_base, r_acc, r_res, r_out;
    logic [EXP_WIDTH-1:0] r_exp;
    logic                 r_out_valid;
    t_mul_sel             r_dest;
    logic [W-1:0]         w_x, w_y, w_rem, w_res;
    logic [W:0]           w_sum, w_diff;
    logic                 w_done;

    // Operand select for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            MS_A_ONE:     begin w_x = r_a;   w_y = W'(1); end
            MS_B_ONE:     begin w_x = r_b;   w_y = W'(1); end
            MS_A_B:       begin w_x = r_a;   w_y = r_b;   end
            MS_ACC_BASE:  begin w_x = r_acc; w_y = r_base; end
            MS_BASE_BASE: begin w_x = r_base; w_y = r_base; end
            MS_ACC_A:     begin w_x = r_acc; w_y = r_a;   end
            default:      begin w_x = r_a;   w_y = r_b;   end
        endcase
    end

    mau_modmul #(.VALUE_WIDTH(W)) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_mod   (i_mod),
        .o_done  (w_done),
        .o_rem   (w_rem)
    );

    // Add, subtract and negate with one conditional correction.
    assign w_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign w_diff = {1'b0, r_a} + {1'b0, i_mod} - {1'b0, r_b};

    always_comb begin
        case (i_cmd.res_sel)
            RS_ADD:  w_res = (w_sum >= {1'b0, i_mod}) ? W'(w_sum - {1'b0, i_mod})
                                                      : w_sum[W-1:0];
            RS_SUB:  w_res = (r_a >= r_b) ? (r_a - r_b) : w_diff[W-1:0];
            RS_NEG:  w_res = (r_a != '0) ? (i_mod - r_a) : '0;
            RS_ACC:  w_res = r_acc;
            default: w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_exp <= i_exp;
        end
        if (i_cmd.mul_start) begin
            r_dest <= i_cmd.mul_sel;
        end
        if (i_cmd.pow_init_a) begin
            r_base <= r_a;
            r_acc  <= W'(1);
            r_exp  <= r_exp;
        end
        if (i_cmd.pow_init_b) begin
            r_base <= r_b;
            r_acc  <= W'(1);
            r_exp  <= EXP_WIDTH'(i_mod) - EXP_WIDTH'(2);
        end
        if (i_cmd.exp_shift) begin
            r_exp <= {1'b0, r_exp[EXP_WIDTH-1:1]};
        end
        // Multiply results go to a, b, acc or base by select, else to res.
        if (w_done) begin
            case (r_dest)
                MS_A_ONE:     r_a    <= w_rem;
                MS_B_ONE:     r_b    <= w_rem;
                MS_ACC_BASE:  r_acc  <= w_rem;
                MS_BASE_BASE: r_base <= w_rem;
                default:      r_res  <= w_rem;
            endcase
        end
        if (i_cmd.res_sel != RS_NONE) begin
            r_res <= w_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Output holding register for the result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result           = r_out;
    assign o_status.mul_done  = w_done;
    assign o_status.exp_zero  = (r_exp == '0);
    assign o_status.exp_lsb   = r_exp[0];
    assign o_status.mod_small = (i_mod < W'(2));
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.op        = r_op;

endmodule

// ----- sv/mau_ctrl.sv -----
// Controller state machine that sequences reductions, multiplies and powers.
module mau_ctrl
    import mau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_issued, n_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_issued   = r_issued;
        o_cmd      = '0;
        o_cmd.mul_sel = MS_A_B;
        o_cmd.res_sel = RS_NONE;
        o_in_ready = (r_state == S_IDLE);

        // A multiply state starts the unit once, then waits for it.
        if (r_state == S_RED_A || r_state == S_RED_B || r_state == S_MUL_AB ||
            r_state == S_POW_ACC || r_state == S_POW_SQ || r_state == S_DIV_FIN) begin
            if (!r_issued) begin
                o_cmd.mul_start = 1'b1;
                n_issued        = 1'b1;
            end else if (i_status.mul_done) begin
                n_issued = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED_A;
                end
            end
            S_RED_A: begin
                o_cmd.mul_sel = MS_A_ONE;
                if (r_issued && i_status.mul_done) n_state = S_RED_B;
            end
            S_RED_B: begin
                o_cmd.mul_sel = MS_B_ONE;
                if (r_issued && i_status.mul_done) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_state = S_EMIT;
                if (i_status.mod_small) begin
                    o_cmd.res_sel = RS_ZERO;
                end else begin
                    case (i_status.op)
                        OP_ADD: o_cmd.res_sel = RS_ADD;
                        OP_SUB: o_cmd.res_sel = RS_SUB;
                        OP_NEG: o_cmd.res_sel = RS_NEG;
                        OP_MUL: n_state = S_MUL_AB;
                        OP_POW: begin
                            o_cmd.pow_init_a = 1'b1;
                            n_state          = S_POW_TEST;
                        end
                        OP_DIV: begin
                            o_cmd.pow_init_b = 1'b1;
                            n_state          = S_POW_TEST;
                        end
                        default: o_cmd.res_sel = RS_ZERO;
                    endcase
                end
            end
            S_MUL_AB: begin
                o_cmd.mul_sel = MS_A_B;
                if (r_issued && i_status.mul_done) n_state = S_EMIT;
            end
            // Square-and-multiply over the exponent, low bit first.
            S_POW_TEST: begin
                if (i_status.exp_zero) begin
                    if (i_status.op == OP_DIV) begin
                        n_state = S_DIV_FIN;
                    end else begin
                        o_cmd.res_sel = RS_ACC;
                        n_state       = S_EMIT;
                    end
                end else if (i_status.exp_lsb) begin
                    n_state = S_POW_ACC;
                end else begin
                    n_state = S_POW_SQ;
                end
            end
            S_POW_ACC: begin
                o_cmd.mul_sel = MS_ACC_BASE;
                if (r_issued && i_status.mul_done) n_state = S_POW_SQ;
            end
            S_POW_SQ: begin
                o_cmd.mul_sel = MS_BASE_BASE;
                if (r_issued && i_status.mul_done) begin
                    o_cmd.exp_shift = 1'b1;
                    n_state         = S_POW_TEST;
                end
            end
            S_DIV_FIN: begin
                o_cmd.mul_sel = MS_ACC_A;
                if (r_issued && i_status.mul_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- sv/modular_arithmetic_unit.sv -----
// Top level of the modular arithmetic unit: stream ports, modulus register, core.
//
// Each input transaction carries an operation (add, subtract, multiply, divide, negate,
// power), two operands and a 63-bit exponent, and yields one result below the modulus
// held in the configuration register at address 0 (reset 998244353). Every operand is
// first reduced through the shared modular multiplier, which reduces the full product one
// bit per cycle. Add, subtract and negate take the two reductions plus an accept, a
// dispatch and an output state; multiply adds one more multiply; power adds one test
// state and up to two multiplies per exponent bit, so up to 126 more multiplies for a
// full 63-bit exponent; divide raises b to the modulus minus two and multiplies by a, up
// to two multiplies per modulus bit plus one. A result that is not taken holds the unit
// in its output state. One transaction is processed at a time; a finished result waits
// in an output register while the next input is taken. The modulus must be written only
// while the unit is idle; the unit itself does not enforce this.
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input tdata, from bit 0: operation, operand_a, operand_b, exponent.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [((OP_WIDTH+2*VALUE_WIDTH+EXP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // Output tdata, from bit 0: result.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int W      = VALUE_WIDTH;
    localparam int OUT_W  = ((W + 7) / 8) * 8;
    localparam int A_LO   = OP_WIDTH;
    localparam int B_LO   = OP_WIDTH + W;
    localparam int E_LO   = OP_WIDTH + 2 * W;

    logic [W-1:0] r_modulus;
    logic [W-1:0] w_result;
    t_cmd         w_cmd;
    t_status      w_status;

    // Configuration register, written in the APB access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= W'(DEFAULT_MODULUS);
        end else if (psel && penable && pwrite && (paddr[2] == REG_MODULUS)) begin
            r_modulus <= pwdata[W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODULUS) ? 32'(r_modulus) : 32'd0;

    mau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mau_datapath #(.VALUE_WIDTH(W)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_mod       (r_modulus),
        .i_op        (s_axis_tdata[OP_WIDTH-1:0]),
        .i_a         (s_axis_tdata[A_LO +: W]),
        .i_b         (s_axis_tdata[B_LO +: W]),
        .i_exp       (s_axis_tdata[E_LO +: EXP_WIDTH]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_result)
    );

    assign m_axis_tdata = OUT_W'(w_result);

endmodule
